@@ src/sound_voice_slot_allocator_assert.svh @@
// assertion macros for the sound voice slot allocator
// included by the top level; empty bodies when SYNTH is defined
`ifndef SOUND_VOICE_SLOT_ALLOCATOR_ASSERT_SVH
`define SOUND_VOICE_SLOT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define SVSA_ASSERT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svsa assertion failed");
`define SVSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svsa assertion failed");
`else
`define SVSA_ASSERT(label, clk, rst, ante, cons)
`define SVSA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ src/svsa_pkg.sv @@
// shared types and constants for the sound voice slot allocator
// used by svsa_cell and sound_voice_slot_allocator; no dependencies
package svsa_pkg;

  localparam int TICK_BITS    = 32;
  localparam int VOLUME_W     = 8;
  localparam int SLOT_INDEX_W = 3;
  localparam int MASK_W       = 8;

  localparam logic [1:0] ACT_FREE    = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_EVICT   = 2'd2;
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  typedef struct packed {
    logic [TICK_BITS-1:0] now_tick;
    logic [TICK_BITS-1:0] sound_length;
    logic [VOLUME_W-1:0]  sound_volume;
    logic                 sound_owned;
  } svsa_req_t;

  typedef struct packed {
    logic [SLOT_INDEX_W-1:0] slot_index;
    logic [1:0]              action;
    logic [MASK_W-1:0]       expired_mask;
  } svsa_rsp_t;

  // per-cycle command from the sequencer to every cell
  typedef struct packed {
    logic load_elapsed;
    logic check;
    logic fill;
    logic restart;
  } svsa_cmd_t;

  // running scan result handed from cell to cell
  typedef struct packed {
    logic                 found_free;
    logic                 found_match;
    logic                 best_valid;
    logic [TICK_BITS-1:0] best_rem;
  } svsa_carry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELAPSE,
    S_CHECK,
    S_SCAN,
    S_APPLY
  } svsa_state_t;

endpackage

@@ src/svsa_cell.sv @@
// one playback slot: its state, expiry check and one step of the scan chain
// depends on svsa_pkg
module svsa_cell import svsa_pkg::*; #(
  parameter int IDX_W    = 3,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  svsa_cmd_t         cmd,
  input  svsa_req_t         req,
  input  logic              wr_sel,
  input  svsa_carry_t       cin,
  input  logic [IDX_W-1:0]  cin_free_idx,
  input  logic [IDX_W-1:0]  cin_match_idx,
  input  logic [IDX_W-1:0]  cin_best_idx,
  output svsa_carry_t       cout,
  output logic [IDX_W-1:0]  cout_free_idx,
  output logic [IDX_W-1:0]  cout_match_idx,
  output logic [IDX_W-1:0]  cout_best_idx,
  output logic              expired
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic                 busy;
  logic [TICK_BITS-1:0] start_tick;
  logic [TICK_BITS-1:0] length;
  logic [VOLUME_W-1:0]  volume;
  logic                 owned;
  logic [TICK_BITS-1:0] elapsed;
  logic [TICK_BITS-1:0] rem;

  logic                 timed_out;
  logic                 match_here;
  svsa_carry_t          cout_next;
  logic [IDX_W-1:0]     free_idx_next;
  logic [IDX_W-1:0]     match_idx_next;
  logic [IDX_W-1:0]     best_idx_next;

  assign timed_out  = busy && (elapsed > length);
  assign match_here = (length == req.sound_length) && (volume == req.sound_volume) &&
                      (owned == req.sound_owned);

  always_comb begin
    cout_next      = cin;
    free_idx_next  = cin_free_idx;
    match_idx_next = cin_match_idx;
    best_idx_next  = cin_best_idx;
    if (!cin.found_free && !busy) begin
      cout_next.found_free = 1'b1;
      free_idx_next        = MY_IDX;
    end
    if (!cin.found_match && match_here) begin
      cout_next.found_match = 1'b1;
      match_idx_next        = MY_IDX;
    end
    // strict compare keeps the lower slot on ties
    if (!cin.best_valid || (rem < cin.best_rem)) begin
      cout_next.best_valid = 1'b1;
      cout_next.best_rem   = rem;
      best_idx_next        = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      expired <= 1'b0;
    end else if (cmd.check) begin
      busy    <= busy && !timed_out;
      expired <= timed_out;
    end else if (cmd.fill && wr_sel) begin
      busy    <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_elapsed) begin
      elapsed <= req.now_tick - start_tick;
    end
    if (cmd.check) begin
      rem <= length - elapsed;
    end
    if ((cmd.fill || cmd.restart) && wr_sel) begin
      start_tick <= req.now_tick;
    end
    if (cmd.fill && wr_sel) begin
      length <= req.sound_length;
      volume <= req.sound_volume;
      owned  <= req.sound_owned;
    end
    cout           <= cout_next;
    cout_free_idx  <= free_idx_next;
    cout_match_idx <= match_idx_next;
    cout_best_idx  <= best_idx_next;
  end

endmodule

@@ src/sound_voice_slot_allocator.sv @@
// Sound voice slot allocator: a row of slot cells driven by a small sequencer.
// Depends on svsa_pkg, svsa_cell and sound_voice_slot_allocator_assert.svh.
//
// Usage:
//   req channel (req_valid/req_ready/req) carries one sound request a beat:
//   current tick, sound length, volume and ownership flag.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one beat per request:
//   slot index, action code and the mask of slots freed by expiry.
//   cfg_wr_en/cfg_wr_data write sound_on; while it is zero each request is
//   answered as ignored without touching the slots.
// Sequence:
//   a request walks the cell chain one slot per cycle, through the elapse,
//   check and scan states, and its result is registered in the apply state
//   (an ignored request goes straight to apply); a new request is taken
//   only once the sequencer is back in idle.
// Reset (rst, synchronous) marks every slot free and clears sound_on.
// The response sits in an output register; a stalled receiver holds it, and
// the next request may be accepted meanwhile but waits in the apply state
// until the previous response is taken.
module sound_voice_slot_allocator import svsa_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  svsa_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output svsa_rsp_t rsp,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

`include "sound_voice_slot_allocator_assert.svh"

  localparam int IDX_W = $clog2(SLOT_COUNT);

  svsa_state_t      state;
  svsa_state_t      state_next;
  logic [IDX_W-1:0] scan_cnt;
  logic             scan_last;
  logic             sound_on;
  logic             ignore_req;
  svsa_req_t        req_q;
  svsa_cmd_t        cmd;
  logic             apply_go;
  logic             req_fire;

  svsa_carry_t      carry     [SLOT_COUNT+1];
  logic [IDX_W-1:0] free_idx  [SLOT_COUNT+1];
  logic [IDX_W-1:0] match_idx [SLOT_COUNT+1];
  logic [IDX_W-1:0] best_idx  [SLOT_COUNT+1];
  logic [SLOT_COUNT-1:0] expired_vec;
  logic [SLOT_COUNT-1:0] wr_sel;

  logic [IDX_W-1:0] pick;
  logic [1:0]       act;
  svsa_rsp_t        rsp_next;

  assign req_fire  = req_valid && req_ready;
  assign scan_last = (scan_cnt == IDX_W'(SLOT_COUNT - 1));

  // chain head: nothing found yet
  assign carry[0]     = '0;
  assign free_idx[0]  = '0;
  assign match_idx[0] = '0;
  assign best_idx[0]  = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    assign wr_sel[i] = (pick == IDX_W'(i)) && !ignore_req && apply_go;
    svsa_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .cmd            (cmd),
      .req            (req_q),
      .wr_sel         (wr_sel[i]),
      .cin            (carry[i]),
      .cin_free_idx   (free_idx[i]),
      .cin_match_idx  (match_idx[i]),
      .cin_best_idx   (best_idx[i]),
      .cout           (carry[i+1]),
      .cout_free_idx  (free_idx[i+1]),
      .cout_match_idx (match_idx[i+1]),
      .cout_best_idx  (best_idx[i+1]),
      .expired        (expired_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_cnt <= '0;
      sound_on <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + 1'b1;
      end else begin
        scan_cnt <= '0;
      end
      if (cfg_wr_en) begin
        sound_on <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_q      <= req;
      ignore_req <= !sound_on;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (req_fire) state_next = sound_on ? S_ELAPSE : S_APPLY;
      S_ELAPSE: state_next = S_CHECK;
      S_CHECK:  state_next = S_SCAN;
      S_SCAN:   if (scan_last) state_next = S_APPLY;
      S_APPLY:  if (apply_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready        = 1'b0;
    cmd              = '0;
    apply_go         = 1'b0;
    case (state)
      S_IDLE:   req_ready = 1'b1;
      S_ELAPSE: cmd.load_elapsed = 1'b1;
      S_CHECK:  cmd.check = 1'b1;
      S_APPLY: begin
        apply_go    = !rsp_valid || rsp_ready;
        cmd.fill    = (act == ACT_FREE) || (act == ACT_EVICT);
        cmd.restart = (act == ACT_RESTART);
      end
      default: ;
    endcase
  end

  // decision from the tail of the chain
  always_comb begin
    if (ignore_req) begin
      pick = '0;
      act  = ACT_IGNORED;
    end else if (carry[SLOT_COUNT].found_free) begin
      pick = free_idx[SLOT_COUNT];
      act  = ACT_FREE;
    end else if (carry[SLOT_COUNT].found_match) begin
      pick = match_idx[SLOT_COUNT];
      act  = ACT_RESTART;
    end else begin
      pick = best_idx[SLOT_COUNT];
      act  = ACT_EVICT;
    end
    rsp_next.slot_index   = SLOT_INDEX_W'(pick);
    rsp_next.action       = act;
    rsp_next.expired_mask = ignore_req ? '0 : MASK_W'(expired_vec);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      rsp <= rsp_next;
    end
  end

  `SVSA_ASSERT(a_one_writer, clk, rst, 1'b1, $onehot0(wr_sel))
  `SVSA_ASSERT(a_rsp_from_apply, clk, rst, $rose(rsp_valid), $past(state) == S_APPLY)
  `SVSA_ASSERT(a_ignored_clean, clk, rst, rsp_valid && (rsp.action == ACT_IGNORED),
               (rsp.slot_index == '0) && (rsp.expired_mask == '0))
  `SVSA_ASSERT_NEXT(a_scan_ends, clk, rst, (state == S_SCAN) && scan_last,
                    state == S_APPLY)

endmodule

@@ tb/sound_voice_slot_allocator_test.sv @@
// self-checking testbench for sound_voice_slot_allocator: directed and random requests
// depends on svsa_pkg and the allocator rtl; predicts every response beat and compares
`timescale 1ns / 1ps

module sound_voice_slot_allocator_test;
  import svsa_pkg::*;

  localparam int NUM_SLOTS   = 8;
  localparam int SIG_POOL    = 6;
  localparam int CHUNK       = 64;
  localparam int TAIL_CYCLES = 24;
  localparam int CYCLE_LIMIT = 500000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  svsa_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  svsa_rsp_t rsp;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;

  svsa_req_t req_backlog[$];
  svsa_rsp_t alloc_expect[$];
  svsa_rsp_t want;
  int        send_idle_pct = 8;
  int        recv_stall_pct = 83;
  int        error_count = 0;
  int        cycle_count = 0;

  // predicted slot table
  logic                 model_sound_on = 1'b0;
  logic                 model_busy [NUM_SLOTS];
  logic [TICK_BITS-1:0] model_start[NUM_SLOTS];
  logic [TICK_BITS-1:0] model_len  [NUM_SLOTS];
  logic [VOLUME_W-1:0]  model_vol  [NUM_SLOTS];
  logic                 model_own  [NUM_SLOTS];

  // stimulus state: running clock and a small set of recurring sound signatures
  logic [TICK_BITS-1:0] sim_now;
  logic [TICK_BITS-1:0] pool_len[SIG_POOL];
  logic [VOLUME_W-1:0]  pool_vol[SIG_POOL];
  logic                 pool_own[SIG_POOL];

  sound_voice_slot_allocator #(.SLOT_COUNT(NUM_SLOTS)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic svsa_rsp_t allocate_slot(svsa_req_t r);
    svsa_rsp_t            res;
    logic [TICK_BITS-1:0] age;
    logic [TICK_BITS-1:0] left;
    logic [TICK_BITS-1:0] best_left;
    int                   s;
    int                   pick;
    bit                   found;
    res = '0;
    if (!model_sound_on) begin
      res.action = ACT_IGNORED;
      return res;
    end
    for (s = 0; s < NUM_SLOTS; s++) begin
      age = r.now_tick - model_start[s];
      if (model_busy[s] && age > model_len[s]) begin
        model_busy[s] = 1'b0;
        res.expired_mask[s] = 1'b1;
      end
    end
    found = 1'b0;
    pick = 0;
    for (s = 0; s < NUM_SLOTS; s++) begin
      if (!found && !model_busy[s]) begin
        found = 1'b1;
        pick = s;
      end
    end
    if (found) begin
      res.action = ACT_FREE;
    end else begin
      for (s = 0; s < NUM_SLOTS; s++) begin
        if (!found && model_len[s] == r.sound_length && model_vol[s] == r.sound_volume &&
            model_own[s] == r.sound_owned) begin
          found = 1'b1;
          pick = s;
        end
      end
      if (found) begin
        res.action = ACT_RESTART;
      end else begin
        res.action = ACT_EVICT;
        // least remaining time, lowest slot wins a tie
        best_left = model_len[0] - (r.now_tick - model_start[0]);
        for (s = 1; s < NUM_SLOTS; s++) begin
          left = model_len[s] - (r.now_tick - model_start[s]);
          if (left < best_left) begin
            best_left = left;
            pick = s;
          end
        end
      end
    end
    model_busy[pick] = 1'b1;
    model_start[pick] = r.now_tick;
    if (res.action != ACT_RESTART) begin
      model_len[pick] = r.sound_length;
      model_vol[pick] = r.sound_volume;
      model_own[pick] = r.sound_owned;
    end
    res.slot_index = pick[SLOT_INDEX_W-1:0];
    return res;
  endfunction

  function automatic svsa_req_t random_request(int step);
    svsa_req_t r;
    int        pick;
    int        k;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // noise: every field fully random
      r.now_tick = $urandom;
      r.sound_length = $urandom;
      r.sound_volume = VOLUME_W'($urandom);
      r.sound_owned = 1'($urandom);
      return r;
    end
    if ($urandom_range(99) < 3) begin
      sim_now = sim_now + $urandom;
    end else begin
      sim_now = sim_now + $urandom_range(step);
    end
    r.now_tick = sim_now;
    pick = $urandom_range(99);
    if (pick < 60) begin
      k = $urandom_range(SIG_POOL - 1);
      r.sound_length = pool_len[k];
      r.sound_volume = pool_vol[k];
      r.sound_owned = pool_own[k];
    end else begin
      if (pick < 85) begin
        r.sound_length = $urandom_range(16 * step);
      end else begin
        case ($urandom_range(2))
          0: r.sound_length = '0;
          1: r.sound_length = '1;
          default: r.sound_length = step;
        endcase
      end
      r.sound_volume = ($urandom_range(3) == 0) ? VOLUME_W'($urandom)
                                                : VOLUME_W'($urandom_range(128));
      r.sound_owned = 1'($urandom);
    end
    return r;
  endfunction

  // driver: prediction happens on the accepted beat
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
    end else begin
      if (req_valid && req_ready) begin
        alloc_expect.push_back(allocate_slot(req));
      end
      if (!req_valid || req_ready) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req <= req_backlog.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (alloc_expect.size() == 0) begin
          $error("response beat with no request outstanding: slot_index %0d action %0d",
                 rsp.slot_index, rsp.action);
          error_count++;
        end else begin
          want = alloc_expect.pop_front();
          if (rsp.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d", want.slot_index, rsp.slot_index);
            error_count++;
          end
          if (rsp.action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, rsp.action);
            error_count++;
          end
          if (rsp.expired_mask !== want.expired_mask) begin
            $error("expired_mask: expected %02h, actual %02h", want.expired_mask,
                   rsp.expired_mask);
            error_count++;
          end
        end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_req(logic [31:0] now, logic [31:0] len, logic [7:0] vol, logic own);
    svsa_req_t r;
    r.now_tick = now;
    r.sound_length = len;
    r.sound_volume = vol;
    r.sound_owned = own;
    req_backlog.push_back(r);
  endtask

  // hold the sender until every outstanding beat has come back
  task automatic drain();
    while (req_backlog.size() != 0 || req_valid || alloc_expect.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_sound(logic on);
    drain();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= on;
    model_sound_on = on;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_random(int count, int step);
    int k;
    int n;
    for (k = 0; k < SIG_POOL; k++) begin
      pool_len[k] = $urandom_range(12 * step, step);
      pool_vol[k] = VOLUME_W'($urandom);
      pool_own[k] = 1'($urandom);
    end
    for (n = 0; n < count; n++) begin
      req_backlog.push_back(random_request(step));
      if (n % CHUNK == CHUNK - 1) begin
        if ((n / CHUNK) % 3 == 2) begin
          drain();
        end else begin
          while (req_backlog.size() != 0) @(negedge clk);
        end
      end
    end
    drain();
  endtask

  initial begin
    int k;
    for (k = 0; k < NUM_SLOTS; k++) begin
      model_busy[k] = 1'b0;
      model_start[k] = '0;
      model_len[k] = '0;
      model_vol[k] = '0;
      model_own[k] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sound off: requests are answered as ignored
    set_sound(1'b0);
    push_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
    push_req(32'h0, 32'h0, 8'h0, 1'b0);
    set_sound(1'b1);
    push_req(32'd0, 32'd100, 8'd128, 1'b0);
    push_req(32'd10, 32'd0, 8'd0, 1'b0);
    // zero-length sound expires one tick later
    push_req(32'd11, 32'hFFFF_FFFF, 8'd255, 1'b1);
    for (k = 0; k < 6; k++) push_req(32'd20 + k, 32'd1000, 8'd64, 1'b1);
    // table full, signature matches slot 2
    push_req(32'd30, 32'd1000, 8'd64, 1'b1);
    // table full, no match: evict the slot closest to its end
    push_req(32'd40, 32'd500, 8'd1, 1'b0);
    // tick near wrap: almost everything expires
    push_req(32'hFFFF_FFF0, 32'hFFFF_FF00, 8'd2, 1'b0);
    // same start and length on six slots, then an eviction tie
    for (k = 0; k < 6; k++) push_req(32'h20, 32'd50, 8'(10 + k), 1'b0);
    push_req(32'h20, 32'd50, 8'd16, 1'b1);
    push_req(32'h20, 32'hFFFF_FFFF, 8'd255, 1'b1);
    drain();

    sim_now = 32'h1000;
    run_random(350, 40);

    set_sound(1'b0);
    run_random(40, 40);

    set_sound(1'b1);
    send_idle_pct = 83;
    recv_stall_pct = 8;
    sim_now = 32'hFFFF_F000;
    run_random(350, 40);

    set_sound(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    sim_now = $urandom;
    run_random(400, 60);

    set_sound(1'b0);
    run_random(20, 60);

    repeat (TAIL_CYCLES) @(negedge clk);
    if (alloc_expect.size() != 0) begin
      $error("%0d response beats never arrived", alloc_expect.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
